/* rtl/multi_quadrature_decoder_saturating_core_defines.svh */
// Assertion macros for the multi-lane quadrature decoder.
// Included by the top level; depends on nothing else.
`ifndef MULTI_QUADRATURE_DECODER_SATURATING_CORE_DEFINES_SVH
`define MULTI_QUADRATURE_DECODER_SATURATING_CORE_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define MQD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define MQD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mqd_pkg.sv */
// Shared constants, step direction type and transition table for the decoder.
// No dependencies; used by every module of the block.
package mqd_pkg;

	localparam int PIN_WIDTH      = 8;
	localparam int PIN_LANES      = PIN_WIDTH / 2;
	localparam int SCALE_WIDTH    = 4;
	localparam int FIELD_WIDTH    = 7;
	localparam int OUT_LANES      = 4;
	localparam int S_TDATA_WIDTH  = 16;
	localparam int M_TDATA_WIDTH  = 32;

	localparam int ENCODER_COUNT_DEF = 4;
	localparam int VALUE_LIMIT_DEF   = 128;

	typedef enum logic [1:0] {
		DIR_HOLD,
		DIR_UP,
		DIR_DOWN
	} dir_t;

	// Transition table: index is {previous pair, current pair}.
	// Double-bit changes and no change both hold.
	function automatic dir_t step_dir(input logic [3:0] idx);
		dir_t d;
		unique case (idx)
			4'd2, 4'd4, 4'd11, 4'd13: d = DIR_UP;
			4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_DOWN;
			default:                  d = DIR_HOLD;
		endcase
		return d;
	endfunction

endpackage

/* rtl/mqd_lane.sv */
// One encoder lane: previous pin pair, table lookup and saturating position.
// Depends on mqd_pkg.
module mqd_lane #(
	parameter int PosWidth   = 7,
	parameter int ValueLimit = 128,
	parameter bit Scaled     = 1'b0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  logic [1:0]                       pins,
	input  logic [mqd_pkg::SCALE_WIDTH-1:0]  scale,
	output logic [PosWidth-1:0]              position
);

	localparam int SumWidth = PosWidth + mqd_pkg::SCALE_WIDTH + 2;

	logic [1:0]          last_pins_q;
	logic [PosWidth-1:0] pos_q;
	logic [PosWidth-1:0] pos_d;
	mqd_pkg::dir_t       dir;
	logic [SumWidth-1:0] mag;
	logic [SumWidth-1:0] pos_ext;
	logic [SumWidth-1:0] sum;

	// Direction from the transition table; lane zero scales its step
	always_comb begin
		dir     = mqd_pkg::step_dir({last_pins_q, pins});
		mag     = Scaled ? SumWidth'(scale) : SumWidth'(1);
		pos_ext = SumWidth'(pos_q);
		pos_d   = pos_q;
		case (dir)
			mqd_pkg::DIR_UP: begin
				sum = pos_ext + mag;
				if (sum >= SumWidth'(ValueLimit))
					pos_d = PosWidth'(ValueLimit - 1);
				else
					pos_d = sum[PosWidth-1:0];
			end
			mqd_pkg::DIR_DOWN: begin
				sum = pos_ext - mag;
				// borrow out of the top bit means the sum went below zero
				if (sum[SumWidth-1])
					pos_d = '0;
				else
					pos_d = sum[PosWidth-1:0];
			end
			default: begin
				sum = pos_ext;
			end
		endcase
	end

	// Lane state advances once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pins_q <= '0;
			pos_q       <= '0;
		end else if (advance) begin
			last_pins_q <= pins;
			pos_q       <= pos_d;
		end
	end

	assign position = pos_q;

endmodule

/* rtl/mqd_merge.sv */
// Output stage: result valid flag, flow control and packing of lane positions.
// Depends on mqd_pkg.
module mqd_merge #(
	parameter int EncoderCount = 4,
	parameter int PosWidth     = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	output logic                                advance,
	input  logic [EncoderCount*PosWidth-1:0]    positions,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mqd_pkg::M_TDATA_WIDTH-1:0]   out_data
);

	logic                                                    valid_q;
	logic [mqd_pkg::OUT_LANES*mqd_pkg::FIELD_WIDTH-1:0]      fields;

	// Take a new item when the held result is empty or leaves this cycle
	assign in_ready = !valid_q || out_ready;
	assign advance  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	// Low bits of each present lane; absent lanes read zero
	for (genvar k = 0; k < mqd_pkg::OUT_LANES; k++) begin : g_field
		if (k < EncoderCount) begin : g_live
			assign fields[k*mqd_pkg::FIELD_WIDTH +: mqd_pkg::FIELD_WIDTH] =
				mqd_pkg::FIELD_WIDTH'(positions[k*PosWidth +: PosWidth]);
		end else begin : g_absent
			assign fields[k*mqd_pkg::FIELD_WIDTH +: mqd_pkg::FIELD_WIDTH] = '0;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = mqd_pkg::M_TDATA_WIDTH'(fields);

endmodule

/* rtl/multi_quadrature_decoder_saturating_core.sv */
// Multi-lane quadrature decoder with saturating position counters.
// One item is one poll of the encoder pins plus the speed scale for encoder
// zero; each item yields one result with the four clamped positions. Every
// encoder has its own lane that decodes and updates in the accepting cycle,
// so an item is taken every clock while the output is empty or draining, and
// its result appears in the next cycle, held in the output stage until taken.
// Lanes beyond the eight pin bits see pin pair 00; result fields of absent
// lanes are zero. Depends on mqd_pkg, mqd_lane, mqd_merge and the defines header.
`include "multi_quadrature_decoder_saturating_core_defines.svh"

module multi_quadrature_decoder_saturating_core #(
	parameter int ENCODER_COUNT = mqd_pkg::ENCODER_COUNT_DEF,
	parameter int VALUE_LIMIT   = mqd_pkg::VALUE_LIMIT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [7:0] pin_sample, [11:8] speed_scale, [15:12] zero
	input  logic [mqd_pkg::S_TDATA_WIDTH-1:0]   s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [6:0] enc0_value, [13:7] enc1_value, [20:14] enc2_value,
	// [27:21] enc3_value, [31:28] zero
	output logic [mqd_pkg::M_TDATA_WIDTH-1:0]   m_axis_tdata
);

	localparam int PosWidth = $clog2(VALUE_LIMIT);

	logic [mqd_pkg::PIN_WIDTH-1:0]     pin_sample;
	logic [mqd_pkg::SCALE_WIDTH-1:0]   speed_scale;
	logic                              advance;
	logic [ENCODER_COUNT*PosWidth-1:0] positions;

	assign pin_sample  = s_axis_tdata[mqd_pkg::PIN_WIDTH-1:0];
	assign speed_scale =
		s_axis_tdata[mqd_pkg::PIN_WIDTH +: mqd_pkg::SCALE_WIDTH];

	// One decoder lane per encoder
	for (genvar i = 0; i < ENCODER_COUNT; i++) begin : g_lane
		logic [1:0] pins;
		if (i < mqd_pkg::PIN_LANES) begin : g_pins
			assign pins = pin_sample[2*i +: 2];
		end else begin : g_nopins
			assign pins = 2'b00;
		end

		mqd_lane #(
			.PosWidth   (PosWidth),
			.ValueLimit (VALUE_LIMIT),
			.Scaled     (i == 0)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.pins     (pins),
			.scale    (speed_scale),
			.position (positions[i*PosWidth +: PosWidth])
		);
	end

	// Result register and packing
	mqd_merge #(
		.EncoderCount (ENCODER_COUNT),
		.PosWidth     (PosWidth)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.advance   (advance),
		.positions (positions),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	// Checks
	`MQD_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, advance, m_axis_tvalid, "accepted item left no result")
	`MQD_ASSERT_NEXT(a_idle_holds_state, clk, arst_n, !advance, $stable(positions), "positions moved without an item")
	`MQD_ASSERT_NEXT(a_zero_scale_holds, clk, arst_n, advance && (speed_scale == '0), $stable(positions[PosWidth-1:0]), "encoder zero moved at zero scale")
	`MQD_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the multi-lane quadrature decoder with clamped positions.
// Needs mqd_pkg and multi_quadrature_decoder_saturating_core; nothing else.

module testbench;
	import mqd_pkg::*;

	localparam int LIMIT_TOP = VALUE_LIMIT_DEF - 1;
	localparam int PAD_LSB   = OUT_LANES * FIELD_WIDTH;

	typedef logic [FIELD_WIDTH-1:0] field_t;

	typedef struct {
		field_t lane_val [OUT_LANES];
	} positions_t;

	// Tracks encoder state and holds the positions still owed by the block
	class decode_scoreboard;
		logic [1:0] prev_pair [OUT_LANES];
		int         pos [OUT_LANES];
		positions_t pending_q [$];
		int         mismatches;
		int         compared;
		int         top_hits;
		int         bottom_hits;

		function new();
			for (int i = 0; i < OUT_LANES; i++) begin
				prev_pair[i] = 2'b00;
				pos[i] = 0;
			end
			mismatches = 0;
			compared = 0;
			top_hits = 0;
			bottom_hits = 0;
		endfunction

		// Gray pair to rank order; one rank down is a forward count, one up is backward
		function dir_t transition_dir(logic [1:0] prev, logic [1:0] cur);
			logic [1:0] r_prev;
			logic [1:0] r_cur;
			logic [1:0] diff;
			r_prev = {prev[1], prev[1] ^ prev[0]};
			r_cur  = {cur[1], cur[1] ^ cur[0]};
			diff   = r_cur - r_prev;
			if (diff == 2'd3)
				return DIR_UP;
			if (diff == 2'd1)
				return DIR_DOWN;
			return DIR_HOLD;
		endfunction

		task note_input(logic [PIN_WIDTH-1:0] pins, logic [SCALE_WIDTH-1:0] scale);
			positions_t want;
			dir_t       d;
			logic [1:0] cur;
			int         delta;
			int         sum;
			for (int i = 0; i < OUT_LANES; i++) begin
				cur = pins[2*i +: 2];
				d = transition_dir(prev_pair[i], cur);
				delta = (d == DIR_UP) ? 1 : (d == DIR_DOWN) ? -1 : 0;
				if (i == 0)
					delta = delta * int'(scale);
				sum = pos[i] + delta;
				if (sum < 0)
					sum = 0;
				else if (sum > LIMIT_TOP)
					sum = LIMIT_TOP;
				pos[i] = sum;
				prev_pair[i] = cur;
				want.lane_val[i] = field_t'(sum);
			end
			pending_q.push_back(want);
		endtask

		task report_mismatch(string what, int got, int want);
			$display("MISMATCH at result %0d, %s: got %0d, expected %0d",
				compared, what, got, want);
			mismatches++;
		endtask

		task check_result(logic [M_TDATA_WIDTH-1:0] word);
			positions_t want;
			field_t     got;
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result", int'(word), 0);
				return;
			end
			want = pending_q.pop_front();
			for (int i = 0; i < OUT_LANES; i++) begin
				got = word[i*FIELD_WIDTH +: FIELD_WIDTH];
				if (got !== want.lane_val[i])
					report_mismatch($sformatf("enc%0d_value", i), int'(got),
						int'(want.lane_val[i]));
				if (got == field_t'(LIMIT_TOP))
					top_hits++;
				if (got == '0)
					bottom_hits++;
			end
			if (word[M_TDATA_WIDTH-1:PAD_LSB] !== '0)
				report_mismatch("pad bits", int'(word[M_TDATA_WIDTH-1:PAD_LSB]), 0);
			compared++;
		endtask
	endclass

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [S_TDATA_WIDTH-1:0] s_axis_tdata = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [M_TDATA_WIDTH-1:0] m_axis_tdata;

	decode_scoreboard sb = new();

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	bit  hold_pending   = 1'b0;
	int  items_sent     = 0;
	int  input_stalls   = 0;

	// Stimulus generator state: per-lane pin pair, direction and run length
	logic [1:0] gen_pair [OUT_LANES];
	bit         gen_up [OUT_LANES];
	int         gen_run [OUT_LANES];

	multi_quadrature_decoder_saturating_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("testbench failed");
		$finish;
	end

	// Handshake monitor: note accepted polls, then check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input(s_axis_tdata[PIN_WIDTH-1:0],
					s_axis_tdata[PIN_WIDTH +: SCALE_WIDTH]);
			if (s_axis_tvalid && !s_axis_tready)
				input_stalls++;
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
		end
	end

	// Result side: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = $urandom_range(80, 120);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Offer one poll item and wait until it is taken
	task send_item(logic [PIN_WIDTH-1:0] pins, logic [SCALE_WIDTH-1:0] scale);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(S_TDATA_WIDTH - PIN_WIDTH - SCALE_WIDTH){1'b0}}, scale, pins};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// Advance every lane one gray step in its direction (or hold, or noise)
	task send_motion(bit noisy, logic [SCALE_WIDTH-1:0] scale);
		logic [PIN_WIDTH-1:0] pins;
		logic [1:0]           r;
		int                   pick;
		for (int i = 0; i < OUT_LANES; i++) begin
			pick = noisy ? $urandom_range(0, 99) : 0;
			if (pick < 80) begin
				r = {gen_pair[i][1], gen_pair[i][1] ^ gen_pair[i][0]};
				r = gen_up[i] ? r - 2'd1 : r + 2'd1;
				gen_pair[i] = {r[1], r[1] ^ r[0]};
			end else if (pick >= 90) begin
				gen_pair[i] = 2'($urandom_range(0, 3));
			end
			if (noisy) begin
				gen_run[i] = gen_run[i] - 1;
				if (gen_run[i] <= 0) begin
					gen_up[i] = ~gen_up[i];
					gen_run[i] = $urandom_range(60, 200);
				end
			end
			pins[2*i +: 2] = gen_pair[i];
		end
		send_item(pins, scale);
	endtask

	task random_phase(int count);
		logic [SCALE_WIDTH-1:0] scale;
		for (int n = 0; n < count; n++) begin
			// Mostly small speed factors, sometimes the full field
			if ($urandom_range(0, 3) == 0)
				scale = SCALE_WIDTH'($urandom_range(0, 15));
			else
				scale = SCALE_WIDTH'($urandom_range(1, 3));
			if ($urandom_range(0, 19) == 0)
				send_item(PIN_WIDTH'($urandom), scale);
			else
				send_motion(1'b1, scale);
		end
	endtask

	initial begin
		// Every ordered pair of pin states, for every lane
		int db_seq [17] = '{0, 0, 1, 0, 2, 0, 3, 1, 1, 2, 1, 3, 2, 2, 3, 3, 0};
		logic [PIN_WIDTH-1:0] pins;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: all transitions incl. double-bit jumps, zero and full scale
		for (int k = 0; k < 17; k++) begin
			for (int i = 0; i < OUT_LANES; i++)
				pins[2*i +: 2] = 2'(db_seq[k]) ^ 2'(i);
			send_item(pins, (k % 3 == 0) ? 4'd0 : (k % 3 == 1) ? 4'd15 : 4'd1);
		end
		for (int i = 0; i < OUT_LANES; i++) begin
			gen_pair[i] = 2'(i);
			gen_up[i] = 1'b1;
			gen_run[i] = $urandom_range(60, 200);
		end
		// Drive encoder zero into its upper clamp at full speed
		repeat (8)
			send_motion(1'b0, 4'd15);

		// Random phases with different idle patterns
		random_phase(170);
		send_idle_pct = 66;
		random_phase(170);
		send_idle_pct = 0;
		recv_stall_pct = 66;
		random_phase(170);
		send_idle_pct = 30;
		recv_stall_pct = 30;
		random_phase(170);
		// Back-pressure burst: result side held off while polls keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_pending = 1'b1;
		random_phase(170);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d poll items, compared %0d results, input stalled %0d cycles.",
			items_sent, sb.compared, input_stalls);
		$display("Fields seen at the upper clamp %0d times, at zero %0d times.",
			sb.top_hits, sb.bottom_hits);
		if (sb.mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
